FILE: sv/wrapping_step_counter_core_assert.svh
// assertion macros for the wrapping step counter core
// expects clk and rst_n in the scope where a macro is used
`ifndef WRAPPING_STEP_COUNTER_CORE_ASSERT_SVH
`define WRAPPING_STEP_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/wsc_pkg.sv
// types and constants shared by the wrapping step counter core
// no dependencies
`default_nettype none

package wsc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_LOAD      = 2'd1,
    MODE_RESTART   = 2'd2,
    MODE_RECOMPUTE = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] REG_START_VALUE = 2'd1;
  localparam logic [1:0] REG_END_VALUE   = 2'd2;

  localparam logic signed [31:0] CNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;

  localparam logic signed [31:0] STEP_SIZE_RST   = 32'sd1;
  localparam logic signed [31:0] START_VALUE_RST = 32'sd0;
  localparam logic signed [31:0] END_VALUE_RST   = CNT_MAX;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] load_value;
  } wsc_in_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic               count_valid;
    logic               start_over;
    logic               at_end;
  } wsc_out_t;

  typedef struct packed {
    logic signed [31:0] step_size;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
  } wsc_cfg_t;

  typedef struct packed {
    logic signed [31:0] next_count;
    logic               wrap;
  } wsc_step_t;

endpackage

`default_nettype wire

FILE: sv/wsc_step.sv
// one counter step: add the signed step, test the wrap bound, pick the restart value
// depends on wsc_pkg
`default_nettype none

module wsc_step
  import wsc_pkg::*;
(
  input  wire wsc_cfg_t          cfg,
  input  wire logic signed [31:0] count_in,
  output wsc_step_t              step
);

  localparam logic signed [33:0] SatHi = {{2{CNT_MAX[31]}}, CNT_MAX};
  localparam logic signed [33:0] SatLo = {{2{CNT_MIN[31]}}, CNT_MIN};

  logic signed [33:0] n_ext;
  logic signed [33:0] s_ext;
  logic signed [33:0] e_ext;
  logic signed [33:0] i_ext;
  logic signed [33:0] delta;
  logic signed [33:0] sum;
  logic signed [33:0] rst_sum;
  logic signed [31:0] rst_sat;
  logic               fwd_range;
  logic               rev_range;
  logic               step_neg;
  logic               active;
  logic               wrap;

  // 34 bits keep every add and compare free of overflow
  always_comb begin
    n_ext     = {{2{count_in[31]}}, count_in};
    s_ext     = {{2{cfg.start_value[31]}}, cfg.start_value};
    e_ext     = {{2{cfg.end_value[31]}}, cfg.end_value};
    i_ext     = {{2{cfg.step_size[31]}}, cfg.step_size};
    fwd_range = cfg.end_value > cfg.start_value;
    rev_range = cfg.end_value < cfg.start_value;
    step_neg  = cfg.step_size[31];
    active    = (fwd_range || rev_range) && (cfg.step_size != 32'sd0);
    delta     = fwd_range ? i_ext : -i_ext;
    sum       = n_ext + delta;
    rst_sum   = e_ext + delta;

    if (rst_sum > SatHi) begin
      rst_sat = CNT_MAX;
    end else if (rst_sum < SatLo) begin
      rst_sat = CNT_MIN;
    end else begin
      rst_sat = rst_sum[31:0];
    end

    case ({step_neg, fwd_range})
      2'b01:   wrap = sum >= e_ext;
      2'b00:   wrap = sum <= e_ext;
      2'b11:   wrap = sum < s_ext;
      default: wrap = sum > s_ext;
    endcase

    step.wrap = active && wrap;
    if (!active) begin
      step.next_count = count_in;
    end else if (wrap) begin
      step.next_count = step_neg ? rst_sat : cfg.start_value;
    end else begin
      step.next_count = sum[31:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/wrapping_step_counter_core.sv
// an accepted input transaction passes the input register, then the result register,
// before its result shows on the output
// throughput: one transaction per cycle while out_stall allows, set by the single
// add/compare step between the input register and the result register
// reset (rst_n low, synchronous): both stages empty, count state zero, step 1,
// start 0, end 0x7fffffff; no clearing pass
`default_nettype none
`include "wrapping_step_counter_core_assert.svh"

module wrapping_step_counter_core
  import wsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire wsc_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output wsc_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic               in_valid_r;
  wsc_in_t            in_data_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  wsc_out_t           out_data_r;
  wsc_out_t           out_data_nxt;
  logic signed [31:0] next_count_r;
  logic signed [31:0] next_count_nxt;
  logic signed [31:0] last_count_r;
  logic signed [31:0] last_count_nxt;
  logic               wrap_pending_r;
  logic               wrap_pending_nxt;
  wsc_cfg_t           cfg_r;
  logic signed [31:0] step_base;
  wsc_step_t          step;
  logic               proc;
  logic               in_take;

  assign cfg_ready = 1'b1;
  assign proc      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !proc;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign step_base = (in_data_r.mode == MODE_TICK) ? next_count_r : last_count_r;

  wsc_step u_step (
    .cfg      (cfg_r),
    .count_in (step_base),
    .step     (step)
  );

  always_comb begin
    next_count_nxt   = next_count_r;
    last_count_nxt   = last_count_r;
    wrap_pending_nxt = wrap_pending_r;
    out_data_nxt     = '0;
    case (in_data_r.mode)
      MODE_TICK: begin
        out_data_nxt.count       = next_count_r;
        out_data_nxt.count_valid = 1'b1;
        out_data_nxt.start_over  = wrap_pending_r;
        out_data_nxt.at_end      = step.wrap;
        last_count_nxt           = next_count_r;
        next_count_nxt           = step.next_count;
        wrap_pending_nxt         = step.wrap;
      end
      MODE_LOAD: begin
        next_count_nxt = in_data_r.load_value;
      end
      MODE_RESTART: begin
        next_count_nxt = cfg_r.start_value;
      end
      default: begin
        // recompute keeps any flag left from an earlier wrap
        next_count_nxt      = step.next_count;
        wrap_pending_nxt    = wrap_pending_r || step.wrap;
        out_data_nxt.at_end = wrap_pending_r || step.wrap;
      end
    endcase
  end

  always_comb begin
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      next_count_r   <= '0;
      last_count_r   <= '0;
      wrap_pending_r <= 1'b0;
      cfg_r.step_size   <= STEP_SIZE_RST;
      cfg_r.start_value <= START_VALUE_RST;
      cfg_r.end_value   <= END_VALUE_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end
      if (proc) begin
        next_count_r   <= next_count_nxt;
        last_count_r   <= last_count_nxt;
        wrap_pending_r <= wrap_pending_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE:   cfg_r.step_size   <= cfg_data;
          REG_START_VALUE: cfg_r.start_value <= cfg_data;
          REG_END_VALUE:   cfg_r.end_value   <= cfg_data;
          default:         ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (proc) begin
      out_data_r <= out_data_nxt;
    end
  end

  `WSC_ASSERT_NOW(a_start_over_on_tick, out_valid_r && out_data_r.start_over,
    out_data_r.count_valid, "start_over without a count")
  `WSC_ASSERT_NEXT(a_pending_matches_at_end,
    proc && (in_data_r.mode == MODE_TICK || in_data_r.mode == MODE_RECOMPUTE),
    wrap_pending_r == out_data_r.at_end, "wrap flag differs from reported at_end")
  `WSC_ASSERT_NEXT(a_in_reg_holds, in_valid_r && !proc,
    in_valid_r && $stable(in_data_r), "input register overwritten before use")
  `WSC_ASSERT_NEXT(a_zero_step_holds,
    proc && in_data_r.mode == MODE_TICK && cfg_r.step_size == 32'sd0,
    next_count_r == $past(next_count_r) && !wrap_pending_r, "zero step moved the count")

endmodule

`default_nettype wire

FILE: test/wrapping_step_counter_core_tb.sv
// self-checking testbench for wrapping_step_counter_core: random traffic with bursts and
// stalls, results checked against an in-bench model of the wrapping counter
// depends on wsc_pkg and the wrapping_step_counter_core rtl
`timescale 1ns / 100ps

module wrapping_step_counter_core_tb;
  import wsc_pkg::*;

  localparam int RANDOM_PHASES = 14;
  localparam int OPS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED   = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  wsc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  wsc_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_STEP_SIZE;
  logic [31:0] cfg_data = '0;

  wrapping_step_counter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // counter model state
  logic signed [31:0] cfg_step = STEP_SIZE_RST;
  logic signed [31:0] cfg_start = START_VALUE_RST;
  logic signed [31:0] cfg_end = END_VALUE_RST;
  logic signed [31:0] next_cnt = '0;
  logic signed [31:0] last_cnt = '0;
  logic               wrap_flag = 1'b0;

  wsc_in_t  op_queue[$];
  wsc_out_t expected_out[$];
  int       mismatch_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_style = 0;
  int stall_span = 0;

  function automatic longint clamp32(input longint v);
    if (v > longint'(CNT_MAX)) return longint'(CNT_MAX);
    if (v < longint'(CNT_MIN)) return longint'(CNT_MIN);
    return v;
  endfunction

  // one step of the counter, done at 64 bits so nothing overflows
  function automatic void advance_count();
    longint s, e, i, n;
    s = longint'(cfg_start);
    e = longint'(cfg_end);
    i = longint'(cfg_step);
    n = longint'(next_cnt);
    if (e > s && i > 0) begin
      n = n + i;
      if (n >= e) begin
        n = s;
        wrap_flag = 1'b1;
      end
    end else if (e < s && i > 0) begin
      n = n - i;
      if (n <= e) begin
        n = s;
        wrap_flag = 1'b1;
      end
    end else if (e > s && i < 0) begin
      n = n + i;
      if (n < s) begin
        n = clamp32(e + i);
        wrap_flag = 1'b1;
      end
    end else if (e < s && i < 0) begin
      n = n - i;
      if (n > s) begin
        n = clamp32(e - i);
        wrap_flag = 1'b1;
      end
    end
    next_cnt = 32'(clamp32(n));
  endfunction

  function automatic wsc_out_t counter_response(input wsc_in_t op);
    wsc_out_t r;
    r = '0;
    case (op.mode)
      MODE_TICK: begin
        r.count = next_cnt;
        r.count_valid = 1'b1;
        last_cnt = next_cnt;
        if (wrap_flag) begin
          wrap_flag = 1'b0;
          r.start_over = 1'b1;
        end
        advance_count();
        r.at_end = wrap_flag;
      end
      MODE_LOAD: next_cnt = op.load_value;
      MODE_RESTART: next_cnt = cfg_start;
      default: begin
        // the pending flag is not cleared here; a new wrap sets it
        next_cnt = last_cnt;
        advance_count();
        r.at_end = wrap_flag;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTED)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input wsc_out_t got);
    wsc_out_t want;
    if (expected_out.size() == 0) begin
      report_mismatch("unexpected result, count", longint'(got.count), longint'(0));
    end else begin
      want = expected_out.pop_front();
      if (got.count !== want.count)
        report_mismatch("count", longint'(got.count), longint'(want.count));
      if (got.count_valid !== want.count_valid)
        report_mismatch("count_valid", longint'(got.count_valid),
                        longint'(want.count_valid));
      if (got.start_over !== want.start_over)
        report_mismatch("start_over", longint'(got.start_over), longint'(want.start_over));
      if (got.at_end !== want.at_end)
        report_mismatch("at_end", longint'(got.at_end), longint'(want.at_end));
    end
  endtask

  // input driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_out.push_back(counter_response(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_data <= op_queue.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; stall style changes after a randomly drawn span
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        check_result(out_data);
      if (stall_span == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_span = $urandom_range(10, 80);
      end else begin
        stall_span--;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || expected_out.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic signed [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_STEP_SIZE: cfg_step = value;
      REG_START_VALUE: cfg_start = value;
      REG_END_VALUE: cfg_end = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [31:0] step, input logic signed [31:0] lo,
                            input logic signed [31:0] hi);
    wait_idle();
    write_reg(REG_STEP_SIZE, step);
    write_reg(REG_START_VALUE, lo);
    write_reg(REG_END_VALUE, hi);
  endtask

  task automatic add_op(input mode_t m, input logic signed [31:0] v);
    wsc_in_t op;
    op.mode = m;
    op.load_value = v;
    op_queue.push_back(op);
  endtask

  // mostly small values so wraps happen often, sometimes extremes or anything
  function automatic logic signed [31:0] pick_value(input int spread);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(2 * spread) - spread;
      6: return CNT_MIN;
      7: return CNT_MAX;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int    phase;
    int    k;
    int    sel;
    mode_t m;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: step 1 from 0 up to the top of the range
    add_op(MODE_TICK, $urandom);
    add_op(MODE_RECOMPUTE, $urandom);
    add_op(MODE_LOAD, CNT_MAX - 1);
    add_op(MODE_TICK, $urandom);
    // recompute keeps the wrap flag pending
    add_op(MODE_RECOMPUTE, $urandom);
    add_op(MODE_RECOMPUTE, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_RESTART, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_LOAD, CNT_MIN);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_LOAD, 32'shFFFF_FFFF);
    add_op(MODE_TICK, $urandom);

    // backward with end below start, restart value saturates high
    set_config(CNT_MIN, 10, 3);
    add_op(MODE_RESTART, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_TICK, $urandom);

    // backward with end above start, restart value saturates low
    set_config(CNT_MIN, CNT_MIN, -5);
    add_op(MODE_RESTART, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_TICK, $urandom);

    // forward with end below start, largest step
    set_config(CNT_MAX, CNT_MAX, CNT_MIN);
    add_op(MODE_RESTART, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_TICK, $urandom);
    add_op(MODE_TICK, $urandom);

    // zero step, then equal bounds: count holds
    set_config(0, -4, 9);
    add_op(MODE_TICK, $urandom);
    set_config(3, 7, 7);
    add_op(MODE_TICK, $urandom);

    // random phases; each config change waits for the pipe to drain
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_config(pick_value(6), pick_value(20), pick_value(20));
      add_op(MODE_RESTART, $urandom);
      for (k = 0; k < OPS_PER_PHASE; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 12) m = MODE_TICK;
        else if (sel < 15) m = MODE_RECOMPUTE;
        else if (sel < 18) m = MODE_LOAD;
        else m = MODE_RESTART;
        add_op(m, (m == MODE_LOAD) ? pick_value(25) : $urandom);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("wrapping_step_counter_core regression: pass");
    else
      $display("wrapping_step_counter_core regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("[%0t] timeout", $time);
    $display("wrapping_step_counter_core regression: fail");
    $finish;
  end

endmodule
